### hdl/lpfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfc_pkg
// Shared types and codes of the length-prefixed frame checker: parser phases,
// result kinds, frame status codes, register indexes and the queued record.
// ----------------------------------------------------------------------------
package lpfc_pkg;

    typedef enum logic [2:0] {
        PH_TLEN    = 3'd0,
        PH_PLEN    = 3'd1,
        PH_TOPIC   = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC     = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_TOPIC   = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_STATUS  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CRC   = 2'd1,
        ST_LONG  = 2'd2,
        ST_TRUNC = 2'd3
    } status_t;

    localparam logic [1:0] CFG_MAX_TOPIC   = 2'd0;
    localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd1;

    localparam int TOPIC_LIM_W   = 16;
    localparam int PAYLOAD_LIM_W = 21;

    localparam logic [TOPIC_LIM_W-1:0]   MAX_TOPIC_RESET   = 16'd255;
    localparam logic [PAYLOAD_LIM_W-1:0] MAX_PAYLOAD_RESET = 21'd4096;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // everything one received word leads to: an optional data byte and an
    // optional status, in that order
    typedef struct packed {
        logic        has_byte;
        kind_t       byte_kind;
        logic [7:0]  data;
        logic        has_status;
        status_t     status;
        logic [31:0] crc;
    } lpfc_rec_t;

endpackage

### hdl/length_prefixed_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_checker
// Deframer for length-prefixed frames with CRC-32 check: topic and payload
// bytes pass out tagged, and a status word closes every frame.
// ----------------------------------------------------------------------------
// One received word is taken per clock while full is low. The parser and the
// bit-wise CRC-32 update (eight steps unrolled) handle a word combinationally
// and drop its results into a QUEUE_DEPTH-entry queue; the output register
// hands out one result per cycle while pop is high, so a word that yields a
// data byte and a truncation status gives the result side two results and
// full rises only when that side falls behind. A word's results pass through
// the queue and then the output register before they reach the result ports.
// Limit registers are written through cfg_valid/cfg_ready (always ready) and
// apply from the next length check onward.
module length_prefixed_frame_checker
    import lpfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [7:0]               in_byte,
    input  logic                     end_of_buffer,
    output logic                     empty,
    input  logic                     pop,
    output logic [1:0]               out_kind,
    output logic [7:0]               out_byte,
    output logic [1:0]               frame_status,
    output logic [31:0]              computed_crc,
    output logic                     last_result,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [PAYLOAD_LIM_W-1:0] cfg_data
);

    logic [TOPIC_LIM_W-1:0]   max_topic_reg;
    logic [PAYLOAD_LIM_W-1:0] max_payload_reg;

    logic      take;
    logic      rec_wr;
    lpfc_rec_t rec;
    logic      q_rd;
    lpfc_rec_t q_rec;
    logic      q_full;
    logic      q_nonempty;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign take      = push && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_topic_reg   <= MAX_TOPIC_RESET;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_TOPIC:   max_topic_reg   <= cfg_data[TOPIC_LIM_W-1:0];
                CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    lpfc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .in_byte       (in_byte),
        .end_of_buffer (end_of_buffer),
        .topic_limit   (max_topic_reg),
        .payload_limit (max_payload_reg),
        .rec_wr        (rec_wr),
        .rec           (rec)
    );

    lpfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (rec_wr),
        .wr_rec   (rec),
        .rd       (q_rd),
        .rd_rec   (q_rec),
        .full     (q_full),
        .nonempty (q_nonempty)
    );

    lpfc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_nonempty   (q_nonempty),
        .q_rec        (q_rec),
        .q_rd         (q_rd),
        .pop          (pop),
        .empty        (empty),
        .out_kind     (out_kind),
        .out_byte     (out_byte),
        .frame_status (frame_status),
        .computed_crc (computed_crc),
        .last_result  (last_result)
    );

endmodule

### hdl/lpfc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfc_front
// Frame parser: tracks length fields, sections and the CRC field, updates
// the running CRC-32 and classifies each accepted word into a result record.
// ----------------------------------------------------------------------------
module lpfc_front
    import lpfc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     take,
    input  logic [7:0]               in_byte,
    input  logic                     end_of_buffer,
    input  logic [TOPIC_LIM_W-1:0]   topic_limit,
    input  logic [PAYLOAD_LIM_W-1:0] payload_limit,
    output logic                     rec_wr,
    output lpfc_rec_t                rec
);

    phase_t                   phase_reg, phase_next;
    logic [1:0]               idx_reg, idx_next;
    logic [31:0]              tlen_reg, tlen_next;
    logic [31:0]              plen_reg, plen_next;
    logic [PAYLOAD_LIM_W-1:0] rem_reg, rem_next;
    logic [31:0]              crc_reg, crc_next;
    logic [23:0]              rxcrc_reg, rxcrc_next;
    logic                     discard_reg, discard_next;

    logic [31:0] crc_after;
    logic [31:0] tlen_ins;
    logic [31:0] plen_ins;
    logic [23:0] rxcrc_ins;
    logic        in_section;
    logic        len_last;
    logic        too_long;
    logic        crc_last;
    logic        crc_match;
    logic        sect_done;
    logic        status_main;
    logic        trunc;

    function automatic logic [31:0] crc8(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    assign in_section = (phase_reg == PH_TOPIC) || (phase_reg == PH_PAYLOAD);
    assign crc_after  = (phase_reg == PH_CRC) ? crc_reg : crc8(crc_reg, in_byte);
    assign tlen_ins   = tlen_reg | ({24'd0, in_byte} << {idx_reg, 3'b000});
    assign plen_ins   = plen_reg | ({24'd0, in_byte} << {idx_reg, 3'b000});
    assign rxcrc_ins  = rxcrc_reg | ({16'd0, in_byte} << {idx_reg, 3'b000});
    assign len_last   = (phase_reg == PH_PLEN) && (idx_reg == 2'd3);
    assign too_long   = len_last && ((tlen_reg > {16'd0, topic_limit})
                        || (plen_ins > {11'd0, payload_limit}));
    assign crc_last   = (phase_reg == PH_CRC) && (idx_reg == 2'd3);
    assign crc_match  = ~crc_reg == {in_byte, rxcrc_reg};
    assign sect_done  = in_section && (rem_reg <= PAYLOAD_LIM_W'(1));
    assign status_main = !discard_reg && (too_long || crc_last);
    // a flagged word that neither closes the frame nor is dropped cuts it short
    assign trunc      = end_of_buffer && !discard_reg && !status_main;

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        tlen_next    = tlen_reg;
        plen_next    = plen_reg;
        rem_next     = rem_reg;
        crc_next     = crc_reg;
        rxcrc_next   = rxcrc_reg;
        discard_next = discard_reg;
        if (take && !discard_reg)
        begin
            crc_next = crc_after;
            case (phase_reg)
                PH_TLEN:
                begin
                    tlen_next = tlen_ins;
                    idx_next  = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        phase_next = PH_PLEN;
                    end
                end
                PH_PLEN:
                begin
                    plen_next = plen_ins;
                    idx_next  = idx_reg + 2'd1;
                    if (len_last)
                    begin
                        if (too_long)
                        begin
                            discard_next = 1'b1;
                        end
                        else if (tlen_reg != 32'd0)
                        begin
                            phase_next = PH_TOPIC;
                            rem_next   = tlen_reg[PAYLOAD_LIM_W-1:0];
                        end
                        else if (plen_ins != 32'd0)
                        begin
                            phase_next = PH_PAYLOAD;
                            rem_next   = plen_ins[PAYLOAD_LIM_W-1:0];
                        end
                        else
                        begin
                            phase_next = PH_CRC;
                            rem_next   = '0;
                        end
                    end
                end
                PH_TOPIC, PH_PAYLOAD:
                begin
                    rem_next = rem_reg - PAYLOAD_LIM_W'(1);
                    if (sect_done)
                    begin
                        idx_next = 2'd0;
                        if ((phase_reg == PH_TOPIC) && (plen_reg != 32'd0))
                        begin
                            phase_next = PH_PAYLOAD;
                            rem_next   = plen_reg[PAYLOAD_LIM_W-1:0];
                        end
                        else
                        begin
                            phase_next = PH_CRC;
                            rem_next   = '0;
                        end
                    end
                end
                PH_CRC:
                begin
                    rxcrc_next = rxcrc_ins;
                    idx_next   = idx_reg + 2'd1;
                    if (crc_last)
                    begin
                        phase_next = PH_TLEN;
                        tlen_next  = '0;
                        plen_next  = '0;
                        rem_next   = '0;
                        crc_next   = CRC_INIT;
                        rxcrc_next = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_TLEN;
                end
            endcase
        end
        // end of buffer always returns to the start of a frame
        if (take && end_of_buffer)
        begin
            phase_next   = PH_TLEN;
            idx_next     = 2'd0;
            tlen_next    = '0;
            plen_next    = '0;
            rem_next     = '0;
            crc_next     = CRC_INIT;
            rxcrc_next   = '0;
            discard_next = 1'b0;
        end
    end

    // outputs
    always_comb
    begin
        rec.has_byte   = !discard_reg && in_section;
        rec.byte_kind  = (phase_reg == PH_TOPIC) ? KIND_TOPIC : KIND_PAYLOAD;
        rec.data       = in_byte;
        rec.has_status = status_main || trunc;
        if (too_long)
        begin
            rec.status = ST_LONG;
        end
        else if (crc_last)
        begin
            rec.status = crc_match ? ST_OK : ST_CRC;
        end
        else
        begin
            rec.status = ST_TRUNC;
        end
        rec.crc = ~crc_after;
        rec_wr  = take && (rec.has_byte || rec.has_status);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TLEN;
            idx_reg     <= 2'd0;
            tlen_reg    <= '0;
            plen_reg    <= '0;
            rem_reg     <= '0;
            crc_reg     <= CRC_INIT;
            rxcrc_reg   <= '0;
            discard_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            tlen_reg    <= tlen_next;
            plen_reg    <= plen_next;
            rem_reg     <= rem_next;
            crc_reg     <= crc_next;
            rxcrc_reg   <= rxcrc_next;
            discard_reg <= discard_next;
        end
    end

    a_eob_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        take && end_of_buffer |=> (phase_reg == PH_TLEN) && !discard_reg && (idx_reg == 2'd0))
        else $error("end of buffer did not restart the parser");

    a_discard_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        discard_reg |-> !rec_wr)
        else $error("record written while discarding");

endmodule

### hdl/lpfc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfc_queue
// Short first-in first-out queue of result records between parser and
// output stage.
// ----------------------------------------------------------------------------
module lpfc_queue
    import lpfc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr,
    input  lpfc_rec_t wr_rec,
    input  logic      rd,
    output lpfc_rec_t rd_rec,
    output logic      full,
    output logic      nonempty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lpfc_rec_t        mem [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign nonempty = count_reg != '0;
    assign rd_rec   = mem[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (wr)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (rd)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (wr && !rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr && full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd && !nonempty))
        else $error("queue read while empty");

endmodule

### hdl/lpfc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfc_back
// Output stage: holds one record and hands out its data byte and its status
// as separate results, oldest first.
// ----------------------------------------------------------------------------
module lpfc_back
    import lpfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_nonempty,
    input  lpfc_rec_t   q_rec,
    output logic        q_rd,
    input  logic        pop,
    output logic        empty,
    output logic [1:0]  out_kind,
    output logic [7:0]  out_byte,
    output logic [1:0]  frame_status,
    output logic [31:0] computed_crc,
    output logic        last_result
);

    logic      valid_reg, valid_next;
    logic      second_reg, second_next;
    lpfc_rec_t rec_reg, rec_next;
    logic      show_byte;
    logic      done;

    // byte part first, then the status part of the same record
    assign show_byte = rec_reg.has_byte && !second_reg;
    assign done      = valid_reg && pop && !(show_byte && rec_reg.has_status);
    assign q_rd      = q_nonempty && (!valid_reg || done);
    assign empty     = !valid_reg;

    always_comb
    begin
        out_kind     = show_byte ? rec_reg.byte_kind : KIND_STATUS;
        out_byte     = show_byte ? rec_reg.data : 8'd0;
        frame_status = show_byte ? ST_OK : rec_reg.status;
        computed_crc = show_byte ? 32'd0 : rec_reg.crc;
        last_result  = !(show_byte && rec_reg.has_status);
    end

    always_comb
    begin
        valid_next  = valid_reg;
        second_next = second_reg;
        rec_next    = rec_reg;
        if (valid_reg && pop && !done)
        begin
            second_next = 1'b1;
        end
        if (q_rd)
        begin
            valid_next  = 1'b1;
            second_next = 1'b0;
            rec_next    = q_rec;
        end
        else if (done)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    a_rec_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (rec_reg.has_byte || rec_reg.has_status))
        else $error("output stage holds a record with no result");

endmodule

### verif/lpfc_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfc_tb_pkg
// Scoreboard for the length-prefixed frame checker bench: a cycle-free
// deframer that tracks the limits, works out the words each received byte
// should produce and compares them in order with what the block hands out.
// ----------------------------------------------------------------------------
package lpfc_tb_pkg;
    import lpfc_pkg::*;

    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

    typedef struct {
        kind_t       kind;
        logic [7:0]  data;
        status_t     status;
        logic [31:0] crc;
        logic        last;
    } deframed_t;

    // reflected crc-32, one bit per step
    function automatic logic [31:0] crc32_byte(logic [31:0] crc_in, logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    class deframe_scoreboard;
        logic [TOPIC_LIM_W-1:0]   max_topic;
        logic [PAYLOAD_LIM_W-1:0] max_payload;
        phase_t                   phase;
        logic [1:0]               field_idx;
        logic [31:0]              topic_size;
        logic [31:0]              payload_size;
        logic [20:0]              remaining;
        logic [31:0]              crc;
        logic [31:0]              rx_crc;
        logic                     discarding;
        deframed_t                due_results[$];
        int unsigned              errors;

        function new();
            max_topic   = MAX_TOPIC_RESET;
            max_payload = MAX_PAYLOAD_RESET;
            discarding  = 1'b0;
            errors      = 0;
            start_frame();
        endfunction

        function void start_frame();
            phase        = PH_TLEN;
            field_idx    = 2'd0;
            topic_size   = 32'd0;
            payload_size = 32'd0;
            remaining    = 21'd0;
            crc          = CRC_INIT;
            rx_crc       = 32'd0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [PAYLOAD_LIM_W-1:0] value);
            case (idx)
                CFG_MAX_TOPIC:   max_topic = value[TOPIC_LIM_W-1:0];
                CFG_MAX_PAYLOAD: max_payload = value;
                default: ;
            endcase
        endfunction

        function void next_section(phase_t from);
            if (from == PH_PLEN && topic_size != 0)
            begin
                phase     = PH_TOPIC;
                remaining = topic_size[20:0];
            end
            else if ((from == PH_PLEN || from == PH_TOPIC) && payload_size != 0)
            begin
                phase     = PH_PAYLOAD;
                remaining = payload_size[20:0];
            end
            else
            begin
                phase     = PH_CRC;
                field_idx = 2'd0;
                remaining = 21'd0;
            end
        endfunction

        function void push_result(kind_t k, logic [7:0] d, status_t st, logic [31:0] c);
            deframed_t w;
            w.kind   = k;
            w.data   = d;
            w.status = st;
            w.crc    = c;
            w.last   = 1'b0;
            due_results.push_back(w);
        endfunction

        // returns 1 when the byte was parsed rather than dropped
        function bit deframe_word(logic [7:0] b, logic eob);
            int unsigned n;
            logic        status_done;
            logic [4:0]  sh;
            logic [31:0] fin;
            n           = 0;
            status_done = 1'b0;
            sh          = {field_idx, 3'b000};
            if (discarding)
            begin
                if (eob)
                begin
                    start_frame();
                    discarding = 1'b0;
                end
                return 1'b0;
            end
            case (phase)
                PH_TLEN:
                begin
                    crc = crc32_byte(crc, b);
                    topic_size |= {24'd0, b} << sh;
                    if (field_idx == 2'd3)
                    begin
                        field_idx = 2'd0;
                        phase     = PH_PLEN;
                    end
                    else
                        field_idx++;
                end
                PH_PLEN:
                begin
                    crc = crc32_byte(crc, b);
                    payload_size |= {24'd0, b} << sh;
                    if (field_idx == 2'd3)
                    begin
                        field_idx = 2'd0;
                        if (topic_size > max_topic || payload_size > max_payload)
                        begin
                            push_result(KIND_STATUS, 8'd0, ST_LONG, crc ^ CRC_ONES);
                            n++;
                            status_done = 1'b1;
                            discarding  = 1'b1;
                        end
                        else
                            next_section(PH_PLEN);
                    end
                    else
                        field_idx++;
                end
                PH_TOPIC, PH_PAYLOAD:
                begin
                    crc = crc32_byte(crc, b);
                    push_result(phase == PH_TOPIC ? KIND_TOPIC : KIND_PAYLOAD, b, ST_OK, 32'd0);
                    n++;
                    if (remaining != 0)
                        remaining--;
                    if (remaining == 0)
                        next_section(phase);
                end
                default:
                begin
                    rx_crc |= {24'd0, b} << sh;
                    if (field_idx == 2'd3)
                    begin
                        fin = crc ^ CRC_ONES;
                        push_result(KIND_STATUS, 8'd0, (fin == rx_crc) ? ST_OK : ST_CRC, fin);
                        n++;
                        status_done = 1'b1;
                        start_frame();
                    end
                    else
                        field_idx++;
                end
            endcase
            if (eob)
            begin
                // buffer ran out inside a frame that has not been closed yet
                if (!status_done && !(phase == PH_TLEN && field_idx == 2'd0))
                begin
                    push_result(KIND_STATUS, 8'd0, ST_TRUNC, crc ^ CRC_ONES);
                    n++;
                end
                start_frame();
                discarding = 1'b0;
            end
            if (n > 0)
                due_results[due_results.size() - 1].last = 1'b1;
            return 1'b1;
        endfunction

        task report(string what, logic [31:0] want, logic [31:0] got);
            $display("%0t ns: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
            errors++;
        endtask

        task check_word(logic [1:0] kind, logic [7:0] data, logic [1:0] status,
                        logic [31:0] crc_got, logic last);
            deframed_t w;
            if (due_results.size() == 0)
            begin
                report("unexpected word, kind", 32'd0, 32'(kind));
                return;
            end
            w = due_results.pop_front();
            if (kind !== w.kind)
                report("out_kind", 32'(w.kind), 32'(kind));
            if (data !== w.data)
                report("out_byte", 32'(w.data), 32'(data));
            if (status !== w.status)
                report("frame_status", 32'(w.status), 32'(status));
            if (crc_got !== w.crc)
                report("computed_crc", w.crc, crc_got);
            if (last !== w.last)
                report("last_result", 32'(w.last), 32'(last));
        endtask

        task drain_check();
            if (due_results.size() != 0)
                report("words never delivered, count", 32'd0, 32'(due_results.size()));
        endtask
    endclass

endpackage

### verif/length_prefixed_frame_checker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_checker_tb
// Feeds receive buffers of well-formed, corrupted, oversized, cut-short and
// noisy frames through the checker under a range of length limits, with
// random gaps and back-pressure, and checks every word that comes out.
// ----------------------------------------------------------------------------
module length_prefixed_frame_checker_tb;
    import lpfc_pkg::*;
    import lpfc_tb_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 950;
    localparam int NUM_SETTINGS  = 6;

    // indexes the block does not decode
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    logic                     clk;
    logic                     rst_n;
    logic                     push;
    logic                     full;
    logic [7:0]               in_byte;
    logic                     end_of_buffer;
    logic                     empty;
    logic                     pop;
    logic [1:0]               out_kind;
    logic [7:0]               out_byte;
    logic [1:0]               frame_status;
    logic [31:0]              computed_crc;
    logic                     last_result;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [1:0]               cfg_index;
    logic [PAYLOAD_LIM_W-1:0] cfg_data;

    deframe_scoreboard sb;
    logic [7:0]        frame_bytes[$];
    logic [31:0]       build_crc;
    bit                no_idle;
    int unsigned       parsed_words;

    length_prefixed_frame_checker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .in_byte       (in_byte),
        .end_of_buffer (end_of_buffer),
        .empty         (empty),
        .pop           (pop),
        .out_kind      (out_kind),
        .out_byte      (out_byte),
        .frame_status  (frame_status),
        .computed_crc  (computed_crc),
        .last_result   (last_result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic push_word(input logic [7:0] b, input logic eob);
        push          <= 1'b1;
        in_byte       <= b;
        end_of_buffer <= eob;
        do @(posedge clk); while (full !== 1'b0);
        if (sb.deframe_word(b, eob))
            parsed_words++;
        if (!no_idle && $urandom_range(99) < 6)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic put_byte(input logic [7:0] b);
        frame_bytes.push_back(b);
        build_crc = crc32_byte(build_crc, b);
    endtask

    task automatic put_word32(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
        begin
            put_byte(w[8*i +: 8]);
        end
    endtask

    task automatic build_frame(input int unsigned tlen, input int unsigned plen, input bit bad_crc);
        logic [31:0] fin;
        build_crc = CRC_INIT;
        put_word32(tlen);
        put_word32(plen);
        repeat (tlen + plen) put_byte(8'($urandom_range(255)));
        fin = build_crc ^ CRC_ONES;
        if (bad_crc)
            fin ^= 32'h1 << $urandom_range(31);
        for (int i = 0; i < 4; i++)
        begin
            frame_bytes.push_back(fin[8*i +: 8]);
        end
    endtask

    function automatic logic [31:0] over_limit(input logic [31:0] lim);
        if ($urandom_range(1) == 0)
            return lim + 1 + $urandom_range(2);
        return $urandom | 32'h8000_0000;
    endfunction

    function automatic int unsigned pick_len(input logic [31:0] lim, input int unsigned cap);
        int unsigned top;
        top = ($urandom_range(99) < 5) ? 40 : cap;
        return $urandom_range(0, (lim < top) ? lim : top);
    endfunction

    // header that fails the length check, then some bytes to be dropped
    task automatic build_long_header();
        logic [31:0] tlen;
        logic [31:0] plen;
        case ($urandom_range(2))
            0:
            begin
                tlen = over_limit(sb.max_topic);
                plen = $urandom_range(0, sb.max_payload);
            end
            1:
            begin
                tlen = $urandom_range(0, sb.max_topic);
                plen = over_limit(sb.max_payload);
            end
            default:
            begin
                tlen = over_limit(sb.max_topic);
                plen = over_limit(sb.max_payload);
            end
        endcase
        build_crc = CRC_INIT;
        put_word32(tlen);
        put_word32(plen);
        repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(255)));
    endtask

    task automatic send_buffer(input bit cut);
        int unsigned keep;
        keep = frame_bytes.size();
        if (cut && keep > 1)
            keep = $urandom_range(1, keep - 1);
        for (int unsigned i = 0; i < keep; i++)
        begin
            push_word(frame_bytes[i], i == keep - 1);
        end
        frame_bytes.delete();
    endtask

    task automatic random_buffer();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8)
            repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(255)));
        else if (pick < 18)
            build_long_header();
        else
            repeat ($urandom_range(1, 3))
                build_frame(pick_len(sb.max_topic, 6), pick_len(sb.max_payload, 10),
                            $urandom_range(99) < 12);
        send_buffer($urandom_range(99) < 15);
    endtask

    // wait until every expected word is out and trailing dropped bytes are done
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [PAYLOAD_LIM_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.write_reg(idx, value);
    endtask

    task automatic set_limits(input logic [15:0] tlim, input logic [20:0] plim, input bit spare);
        settle();
        cfg_write(CFG_MAX_TOPIC, {5'd0, tlim});
        cfg_write(CFG_MAX_PAYLOAD, plim);
        if (spare)
        begin
            cfg_write(CFG_SPARE_A, PAYLOAD_LIM_W'($urandom));
            cfg_write(CFG_SPARE_B, PAYLOAD_LIM_W'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    // result side: random back-pressure, checks each word taken
    initial
    begin
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop === 1'b1 && empty === 1'b0)
                sb.check_word(out_kind, out_byte, frame_status, computed_crc, last_result);
            pop <= no_idle || ($urandom_range(99) >= 12);
        end
    end

    initial
    begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                stall = 0;
            else
                stall++;
        end
        $display("length_prefixed_frame_checker_tb: errors");
        $finish;
    end

    initial
    begin
        int unsigned target;
        rst_n         = 1'b0;
        push          = 1'b0;
        in_byte       = 8'd0;
        end_of_buffer = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_MAX_TOPIC;
        cfg_data      = '0;
        no_idle       = 1'b0;
        parsed_words  = 0;
        sb            = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short frame closed by the buffer end, an oversized header ending
        // the buffer on its last length byte, and a buffer cut in the header
        build_frame(1, 1, 1'b0);
        send_buffer(1'b0);
        put_word32(32'hFFFF_FFFF);
        put_word32(32'h0000_0000);
        send_buffer(1'b0);
        put_byte(8'h00);
        put_byte(8'hFF);
        send_buffer(1'b0);

        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            case (s)
                0: set_limits(16'd0, 21'd0, 1'b1);
                1: set_limits(16'd3, 21'd5, 1'b0);
                2: set_limits(16'd65535, 21'd1048576, 1'b0);
                3: set_limits(16'($urandom_range(0, 8)), 21'($urandom_range(0, 12)), 1'b1);
                4: set_limits(16'd1, 21'd0, 1'b0);
                default: set_limits(MAX_TOPIC_RESET, MAX_PAYLOAD_RESET, 1'b0);
            endcase
            no_idle = (s == 2);
            target  = parsed_words + RANDOM_ITEMS / NUM_SETTINGS;
            while (parsed_words < target)
                random_buffer();
        end
        no_idle = 1'b0;

        settle();
        sb.drain_check();
        if (sb.errors == 0)
            $display("length_prefixed_frame_checker_tb: clean");
        else
            $display("length_prefixed_frame_checker_tb: errors");
        $finish;
    end

endmodule

### filelist.f
hdl/lpfc_pkg.sv
hdl/lpfc_front.sv
hdl/lpfc_queue.sv
hdl/lpfc_back.sv
hdl/length_prefixed_frame_checker.sv
verif/lpfc_tb_pkg.sv
verif/length_prefixed_frame_checker_tb.sv
